[rtl/core/tecp_pkg.sv]
// tecp_pkg: shared types and constants of the triangle edge crossing block
// used by tecp_ctrl, tecp_datapath and triangle_edge_cross_points_core
`timescale 1ns / 1ps
`default_nettype none

package tecp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int MAX_PTS = 9;
    localparam int IDX_W = $clog2(MAX_PTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_NORM,
        S_TEST,
        S_DIV,
        S_FIN,
        S_DEDUP,
        S_NEXT,
        S_OLOAD,
        S_OWAIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_DEN_A,
        MUL_DEN_B,
        MUL_TN_A,
        MUL_TN_B,
        MUL_UN_A,
        MUL_UN_B
    } mul_sel_t;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             norm;
        logic             div_init;
        logic             div_step;
        logic             fin;
        logic             store;
        logic             out_load;
        logic             out_found;
        logic             out_last;
        logic [IDX_W-1:0] idx;
        logic [1:0]       pi;
        logic [1:0]       pj;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic in_range;
        logic match;
    } sts_t;

    function automatic logic [1:0] next_vtx(input logic [1:0] v);
        logic [1:0] r;
        r = (v == 2'd2) ? 2'd0 : v + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tecp_datapath.sv]
// tecp_datapath: vertex registers, shared multiplier, two division lanes,
// point store and output registers; depends on tecp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tecp_datapath
    import tecp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire cmd_t                          cmd,
    output sts_t                               sts,
    input  wire logic signed [COORD_WIDTH-1:0] in_x [6],
    input  wire logic signed [COORD_WIDTH-1:0] in_y [6],
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic                               found,
    output logic                               last
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int AW = 2 * W + 3;
    localparam int RW = AW + 1;

    logic signed [W-1:0] vx_reg [6];
    logic signed [W-1:0] vy_reg [6];
    logic signed [AW-1:0] den_reg, tn_reg, un_reg;
    logic [DW-1:0] mag_reg [2];
    logic [DW-1:0] q_reg [2];
    logic [RW-1:0] rem_reg [2];
    logic          neg_reg [2];
    logic signed [W-1:0] cand_reg [2];
    logic signed [W-1:0] pts_x_reg [MAX_PTS];
    logic signed [W-1:0] pts_y_reg [MAX_PTS];

    logic [2:0] ia, ib, ic, id;
    logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [DW-1:0] ab_x, ab_y, cd_x, cd_y, ac_x, ac_y, opa, opb;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] pext;
    logic [RW-1:0] den_u, den2_u, un_u;
    logic [RW-1:0] rem_next [2];
    logic [DW-1:0] q_next [2];
    logic signed [DW-1:0] dc [2];
    logic signed [W-1:0] cc [2];
    logic signed [DW:0] qs [2];
    logic signed [DW:0] sum [2];
    logic [RW-1:0] r2;

    always_comb
    begin
        ia = {1'b0, cmd.pi};
        ib = {1'b0, next_vtx(cmd.pi)};
        ic = 3'd3 + {1'b0, cmd.pj};
        id = 3'd3 + {1'b0, next_vtx(cmd.pj)};
        ax = vx_reg[ia];
        ay = vy_reg[ia];
        bx = vx_reg[ib];
        by = vy_reg[ib];
        cx = vx_reg[ic];
        cy = vy_reg[ic];
        dx = vx_reg[id];
        dy = vy_reg[id];
        ab_x = DW'(ax) - DW'(bx);
        ab_y = DW'(ay) - DW'(by);
        cd_x = DW'(cx) - DW'(dx);
        cd_y = DW'(cy) - DW'(dy);
        ac_x = DW'(ax) - DW'(cx);
        ac_y = DW'(ay) - DW'(cy);
        unique case (cmd.mul_sel)
            MUL_DEN_A: begin opa = ab_x; opb = cd_y; end
            MUL_DEN_B: begin opa = ab_y; opb = cd_x; end
            MUL_TN_A:  begin opa = ac_x; opb = cd_y; end
            MUL_TN_B:  begin opa = ac_y; opb = cd_x; end
            MUL_UN_A:  begin opa = ab_x; opb = ac_y; end
            MUL_UN_B:  begin opa = ab_y; opb = ac_x; end
            default:   begin opa = '0;   opb = '0;   end
        endcase
        prod = PW'(opa) * PW'(opb);
        pext = AW'(prod);
        dc[0] = DW'(dx) - DW'(cx);
        dc[1] = DW'(dy) - DW'(cy);
        cc[0] = cx;
        cc[1] = cy;
    end

    assign den_u  = RW'(unsigned'(den_reg));
    assign den2_u = {den_u[RW-2:0], 1'b0};
    assign un_u   = RW'(unsigned'(un_reg));

    always_comb
    begin
        r2 = '0;
        for (int l = 0; l < 2; l++)
        begin
            r2 = {rem_reg[l][RW-2:0], 1'b0} + (mag_reg[l][DW-1] ? un_u : RW'(0));
            if (r2 >= den2_u)
            begin
                rem_next[l] = r2 - den2_u;
                q_next[l]   = {q_reg[l][DW-2:0], 1'b0} + DW'(2);
            end
            else if (r2 >= den_u)
            begin
                rem_next[l] = r2 - den_u;
                q_next[l]   = {q_reg[l][DW-2:0], 1'b0} + DW'(1);
            end
            else
            begin
                rem_next[l] = r2;
                q_next[l]   = {q_reg[l][DW-2:0], 1'b0};
            end
            qs[l] = $signed({1'b0, q_reg[l]});
            if (neg_reg[l])
            begin
                if (rem_reg[l] != '0)
                begin
                    qs[l] = qs[l] + (DW+1)'(1);
                end
                qs[l] = -qs[l];
            end
            sum[l] = (DW+1)'(cc[l]) + qs[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg <= in_x;
            vy_reg <= in_y;
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MUL_DEN_A: den_reg <= pext;
                MUL_DEN_B: den_reg <= den_reg - pext;
                MUL_TN_A:  tn_reg  <= pext;
                MUL_TN_B:  tn_reg  <= tn_reg - pext;
                MUL_UN_A:  un_reg  <= -pext;
                MUL_UN_B:  un_reg  <= un_reg + pext;
                default:   den_reg <= den_reg;
            endcase
        end
        if (cmd.norm && den_reg[AW-1])
        begin
            den_reg <= -den_reg;
            tn_reg  <= -tn_reg;
            un_reg  <= -un_reg;
        end
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.div_init)
            begin
                neg_reg[l] <= dc[l][DW-1];
                mag_reg[l] <= dc[l][DW-1] ? unsigned'(-dc[l]) : unsigned'(dc[l]);
                rem_reg[l] <= '0;
                q_reg[l]   <= '0;
            end
            else if (cmd.div_step)
            begin
                mag_reg[l] <= {mag_reg[l][DW-2:0], 1'b0};
                rem_reg[l] <= rem_next[l];
                q_reg[l]   <= q_next[l];
            end
            if (cmd.fin)
            begin
                cand_reg[l] <= sum[l][W-1:0];
            end
        end
        if (cmd.store)
        begin
            pts_x_reg[cmd.idx] <= cand_reg[0];
            pts_y_reg[cmd.idx] <= cand_reg[1];
        end
        if (cmd.out_load)
        begin
            point_x <= cmd.out_found ? pts_x_reg[cmd.idx] : '0;
            point_y <= cmd.out_found ? pts_y_reg[cmd.idx] : '0;
            found   <= cmd.out_found;
            last    <= cmd.out_last;
        end
    end

    always_comb
    begin
        sts.den_zero = (den_reg == '0);
        sts.in_range = !tn_reg[AW-1] && (tn_reg <= den_reg)
                    && !un_reg[AW-1] && (un_reg <= den_reg);
        sts.match    = (cmd.idx < IDX_W'(MAX_PTS))
                    && (pts_x_reg[cmd.idx] == cand_reg[0])
                    && (pts_y_reg[cmd.idx] == cand_reg[1]);
    end

endmodule

`default_nettype wire

[rtl/core/tecp_ctrl.sv]
// tecp_ctrl: sequencer over every pair of edges of the two triangles, dedup walk and output
// handshake; depends on tecp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tecp_ctrl
    import tecp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int CW = $clog2(DW + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic [1:0] pi_reg, pi_next, pj_reg, pj_next;
    logic [IDX_W-1:0] k_reg, k_next, count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            pi_reg    <= '0;
            pj_reg    <= '0;
            k_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pi_reg    <= pi_next;
            pj_reg    <= pj_next;
            k_reg     <= k_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        k_next     = k_reg;
        count_next = count_reg;
        cmd           = '0;
        cmd.mul_sel   = mul_sel_t'(step_reg[2:0]);
        cmd.pi        = pi_reg;
        cmd.pj        = pj_reg;
        cmd.idx       = k_reg;
        cmd.out_found = (count_reg != '0);
        cmd.out_last  = (count_reg == '0) || (k_reg == count_reg - IDX_W'(1));
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_OWAIT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pi_next    = '0;
                    pj_next    = '0;
                    count_next = '0;
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == CW'(MUL_UN_B))
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sts.den_zero || !sts.in_range)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    step_next    = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == CW'(DW - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                k_next     = '0;
                state_next = S_DEDUP;
            end
            S_DEDUP:
            begin
                if (k_reg == count_reg)
                begin
                    cmd.store  = 1'b1;
                    count_next = count_reg + IDX_W'(1);
                    state_next = S_NEXT;
                end
                else if (sts.match)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_NEXT:
            begin
                step_next  = '0;
                state_next = S_MUL;
                if (pj_reg == 2'd2)
                begin
                    pj_next = '0;
                    if (pi_reg == 2'd2)
                    begin
                        k_next     = '0;
                        state_next = S_OLOAD;
                    end
                    else
                    begin
                        pi_next = pi_reg + 2'd1;
                    end
                end
                else
                begin
                    pj_next = pj_reg + 2'd1;
                end
            end
            S_OLOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (!out_stall)
                begin
                    if (cmd.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_OLOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/triangle_edge_cross_points_core.sv]
// triangle_edge_cross_points_core: top level, joins tecp_ctrl and tecp_datapath
// depends on tecp_pkg, tecp_ctrl, tecp_datapath
`timescale 1ns / 1ps
`default_nettype none

// Takes one pair of triangles per item and returns the distinct crossing points
// of their edges in order, the final one marked last, or a single found=0
// result when there are none. One item is worked at a time. For each pair of
// edges, one per triangle, the products for the denominator and numerators are
// formed on the single shared multiplier, then signs are normalised, the range
// is tested and the pair is advanced. A pair that crosses also runs the
// two-lane bit-serial divider, a finishing step and a walk over the points kept
// so far to drop duplicates. Each result is registered and then held until the
// output side takes it without a stall.
module triangle_edge_cross_points_core
    import tecp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] first_v0_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_v0_y,
    input  wire logic signed [COORD_WIDTH-1:0] first_v1_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_v1_y,
    input  wire logic signed [COORD_WIDTH-1:0] first_v2_x,
    input  wire logic signed [COORD_WIDTH-1:0] first_v2_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_v0_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_v0_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_v1_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_v1_y,
    input  wire logic signed [COORD_WIDTH-1:0] second_v2_x,
    input  wire logic signed [COORD_WIDTH-1:0] second_v2_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic                               found,
    output logic                               last
);

    cmd_t cmd;
    sts_t sts;
    logic signed [COORD_WIDTH-1:0] in_x [6];
    logic signed [COORD_WIDTH-1:0] in_y [6];

    assign in_x = '{first_v0_x, first_v1_x, first_v2_x,
                    second_v0_x, second_v1_x, second_v2_x};
    assign in_y = '{first_v0_y, first_v1_y, first_v2_y,
                    second_v0_y, second_v1_y, second_v2_y};

    tecp_ctrl #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tecp_datapath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .sts     (sts),
        .in_x    (in_x),
        .in_y    (in_y),
        .point_x (point_x),
        .point_y (point_y),
        .found   (found),
        .last    (last)
    );

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench: checks triangle_edge_cross_points_core against an internal predictor
// of the edge crossing points; depends on tecp_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
    import tecp_pkg::*;

    localparam int W = COORD_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 480;

    typedef logic signed [W-1:0] coord_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   found;
        logic   last;
    } point_res_t;
    typedef coord_t tri_pair_t [12];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t in_coord [12];
    logic out_valid;
    logic out_stall = 1'b0;
    coord_t point_x, point_y;
    logic found, last;

    point_res_t crossing_q [$];
    int fail_count = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    triangle_edge_cross_points_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .first_v0_x(in_coord[0]), .first_v0_y(in_coord[1]),
        .first_v1_x(in_coord[2]), .first_v1_y(in_coord[3]),
        .first_v2_x(in_coord[4]), .first_v2_y(in_coord[5]),
        .second_v0_x(in_coord[6]), .second_v0_y(in_coord[7]),
        .second_v1_x(in_coord[8]), .second_v1_y(in_coord[9]),
        .second_v2_x(in_coord[10]), .second_v2_y(in_coord[11]),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .found(found), .last(last)
    );

    function automatic longint floor_quot(longint q, longint d);
        longint r;
        r = q / d;
        if ((q % d) != 0 && q < 0)
            r = r - 1;
        return r;
    endfunction

    task automatic predict_crossings(input tri_pair_t c);
        longint ax, ay, bx, by, cx, cy, dx, dy, den, tn, un, rx, ry;
        longint kx [$];
        longint ky [$];
        bit dup;
        point_res_t r;
        for (int i = 0; i < 3; i++)
        begin
            ax = c[2*i]; ay = c[2*i+1];
            bx = c[2*((i+1)%3)]; by = c[2*((i+1)%3)+1];
            for (int j = 0; j < 3; j++)
            begin
                cx = c[6+2*j]; cy = c[7+2*j];
                dx = c[6+2*((j+1)%3)]; dy = c[7+2*((j+1)%3)];
                den = (ax-bx)*(cy-dy) - (ay-by)*(cx-dx);
                if (den == 0)
                    continue;
                tn = (ax-cx)*(cy-dy) - (ay-cy)*(cx-dx);
                un = -((ax-bx)*(ay-cy) - (ay-by)*(ax-cx));
                if (den < 0)
                begin
                    den = -den; tn = -tn; un = -un;
                end
                if (tn < 0 || tn > den || un < 0 || un > den)
                    continue;
                rx = floor_quot(cx*den + (dx-cx)*un, den);
                ry = floor_quot(cy*den + (dy-cy)*un, den);
                dup = 1'b0;
                foreach (kx[k])
                    if (kx[k] == rx && ky[k] == ry)
                        dup = 1'b1;
                if (!dup && kx.size() < MAX_PTS)
                begin
                    kx = {kx, rx};
                    ky = {ky, ry};
                end
            end
        end
        if (kx.size() == 0)
        begin
            r = '{x: '0, y: '0, found: 1'b0, last: 1'b1};
            crossing_q = {crossing_q, r};
        end
        foreach (kx[k])
        begin
            r.x = coord_t'(kx[k]);
            r.y = coord_t'(ky[k]);
            r.found = 1'b1;
            r.last = (k == kx.size() - 1);
            crossing_q = {crossing_q, r};
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic send_item(input tri_pair_t c);
        @(negedge clk);
        foreach (c[k])
            in_coord[k] <= c[k];
        in_valid <= 1'b1;
        predict_crossings(c);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drop_valid_maybe(input bit keep);
        if (!keep)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom_range(0, 15) * 256) - coord_t'(2048);
        endcase
    endfunction

    // output check and receiver stall pattern
    always @(posedge clk)
    begin
        point_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (crossing_q.size() == 0)
                report_mismatch("unexpected item found", found, 0);
            else
            begin
                want = crossing_q.pop_front();
                if (point_x !== want.x) report_mismatch("point_x", point_x, want.x);
                if (point_y !== want.y) report_mismatch("point_y", point_y, want.y);
                if (found !== want.found) report_mismatch("found", found, want.found);
                if (last !== want.last) report_mismatch("last", last, want.last);
            end
        end
    end

    always @(negedge clk)
    begin
        if ($realtime < 30000.0 || ($realtime > 200000.0 && $realtime < 260000.0))
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    tri_pair_t directed_tab [] = '{
        '{0,0, 1024,0, 0,1024, 0,0, 1024,0, 0,1024},
        '{0,0, 512,0, 0,512, 256,256, 2048,256, 256,2048},
        '{0,0, 0,0, 0,0, 0,0, 0,0, 0,0},
        '{0,0, 256,0, 0,256, 4096,4096, 5120,4096, 4096,5120},
        '{-32768,-32768, 32767,-32768, -32768,32767,
          32767,32767, -32768,32767, 32767,-32768},
        '{-32768,-32768, 32767,32767, -32768,32767,
          -32768,32767, 32767,-32768, 32767,32767},
        '{32767,32767, 32767,32767, 32767,32767, -32768,-32768, -32768,-32768, -32768,-32768},
        '{0,0, 1000,0, 0,1000, 500,-100, 500,1100, -100,500},
        '{0,0, 1000,0, 500,1000, 0,0, 1000,0, 500,-1000},
        '{0,0, 1000,0, 500,1000, 1000,0, 2000,0, 1500,1000},
        '{-1,-1, 3,0, 0,3, 1,-2, 1,5, -3,1},
        '{0,0, 768,0, 0,768, 0,0, -768,0, 0,-768},
        '{-300,-300, 300,-300, 0,300, -300,300, 300,300, 0,-300}
    };

    initial
    begin
        tri_pair_t c;
        int mode;
        foreach (in_coord[k])
            in_coord[k] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: no result values typed in, the predictor computes every row
        foreach (directed_tab[r])
        begin
            send_item(directed_tab[r]);
            drop_valid_maybe(r % 3 != 0);
        end
        drop_valid_maybe(1'b0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 3);
            foreach (c[k])
                c[k] = rand_coord(mode);
            if ($urandom_range(0, 7) == 0)
                c[2*$urandom_range(0, 2) + 1] = c[1];
            send_item(c);
            if (n == N_RANDOM / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (crossing_q.size() == 0);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 400)) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        wait (crossing_q.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
